>>> hw/rtl/mlsf_pkg.sv
// ----------------------------------------------------------------------------
// mlsf_pkg
// Shared types and constants of the learning switch forwarder.
// ----------------------------------------------------------------------------
package mlsf_pkg;

    localparam int MAC_W        = 48;
    localparam int PORT_W       = 2;
    localparam int LEN_W        = 14;
    localparam int MAX_PORTS    = 4;
    localparam int CRC_BYTES    = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int DEF_TABLE_DEPTH   = 64;
    localparam int DEF_NUM_PORTS     = 4;
    localparam int DEF_MIN_FRAME_LEN = 64;
    localparam int DEF_MAX_FRAME_LEN = 1518;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_EN  = 3'd4;

    // result action codes
    localparam logic [1:0] ACT_BAD_LEN = 2'd0;
    localparam logic [1:0] ACT_OWN_MAC = 2'd1;
    localparam logic [1:0] ACT_FORWARD = 2'd2;
    localparam logic [1:0] ACT_FLOOD   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input header
        logic scan_src;   // sweep table looking for source
        logic learn;      // apply learning decision
        logic scan_dst;   // sweep table looking for destination
        logic finish;     // form result
    } mlsf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic len_bad;
        logic scan_last;
    } mlsf_sts_t;

endpackage

>>> hw/rtl/mlsf_datapath.sv
// ----------------------------------------------------------------------------
// mlsf_datapath
// Header registers, MAC table memory, scan counter and decision logic.
// ----------------------------------------------------------------------------
module mlsf_datapath
    import mlsf_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int NUM_PORTS     = DEF_NUM_PORTS,
    parameter int MIN_FRAME_LEN = DEF_MIN_FRAME_LEN,
    parameter int MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [MAC_W-1:0]     cfg_data,
    input  logic [MAC_W-1:0]     in_dest_mac,
    input  logic [MAC_W-1:0]     in_source_mac,
    input  logic [PORT_W-1:0]    in_ingress_port,
    input  logic [LEN_W-1:0]     in_frame_len,
    input  mlsf_cmd_t            cmd,
    output mlsf_sts_t            sts,
    output logic [1:0]           res_action,
    output logic [MAX_PORTS-1:0] res_egress_mask,
    output logic                 res_table_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [MAX_PORTS-1:0] PORTS_MASK = MAX_PORTS'((1 << NUM_PORTS) - 1);

    // table memory, one read and one write port
    logic [MAC_W-1:0]  mem_mac  [TABLE_DEPTH];
    logic [PORT_W-1:0] mem_port [TABLE_DEPTH];
    logic [MAC_W-1:0]  rd_mac_reg;
    logic [PORT_W-1:0] rd_port_reg;
    logic              rd_ok_reg;

    logic [MAC_W-1:0]     own_mac_reg [MAX_PORTS];
    logic [MAX_PORTS-1:0] port_en_reg;
    logic [MAX_PORTS-1:0] overridden_reg;
    logic [CNT_W-1:0]     count_reg;

    logic [MAC_W-1:0]  dst_reg, src_reg;
    logic [PORT_W-1:0] ing_reg;
    logic              len_bad_reg;

    // scan: addr_reg issues reads, rd_ok_reg tags the registered data
    logic [CNT_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [PORT_W-1:0] hit_port_reg;
    logic              scanning;
    logic [LEN_W:0]    len_crc;
    logic              rd_match;
    logic [MAC_W-1:0]  key;
    logic              own_hit;

    assign scanning = cmd.scan_src | cmd.scan_dst;
    assign key      = cmd.scan_dst ? dst_reg : src_reg;
    assign rd_match = rd_ok_reg && (rd_mac_reg == key);
    assign len_crc  = {1'b0, in_frame_len} + (LEN_W+1)'(CRC_BYTES);

    // scan ends once all filled entries have been read back
    assign sts.scan_last = scanning && (addr_reg >= count_reg) && !rd_ok_reg;
    assign sts.len_bad   = len_bad_reg;

    // destination is a live own address of an enabled port
    always_comb begin
        own_hit = 1'b0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (port_en_reg[p] && !overridden_reg[p] && own_mac_reg[p] == dst_reg) begin
                own_hit = 1'b1;
            end
        end
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.learn && !hit_reg && !len_bad_reg && count_reg < CNT_W'(TABLE_DEPTH)) begin
            mem_mac[count_reg[IDX_W-1:0]]  <= src_reg;
            mem_port[count_reg[IDX_W-1:0]] <= ing_reg;
        end else if (cmd.learn && hit_reg) begin
            mem_port[hit_idx_reg] <= ing_reg;
        end
        rd_mac_reg  <= mem_mac[addr_reg[IDX_W-1:0]];
        rd_port_reg <= mem_port[addr_reg[IDX_W-1:0]];
        rd_idx_reg  <= addr_reg[IDX_W-1:0];
    end

    // header capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dst_reg     <= in_dest_mac;
            src_reg     <= in_source_mac;
            ing_reg     <= in_ingress_port;
            len_bad_reg <= (len_crc < (LEN_W+1)'(MIN_FRAME_LEN))
                         || (len_crc > (LEN_W+1)'(MAX_FRAME_LEN));
        end
    end

    // scan control and match capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg  <= '0;
            rd_ok_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else if (scanning) begin
            rd_ok_reg <= addr_reg < count_reg;
            if (addr_reg < count_reg) begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            if (rd_match && !hit_reg) begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= rd_idx_reg;
                hit_port_reg <= rd_port_reg;
            end
        end else begin
            addr_reg  <= '0;
            rd_ok_reg <= 1'b0;
            if (cmd.load || cmd.learn) begin
                hit_reg <= 1'b0;
            end
        end
    end

    // configuration, learning state and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < MAX_PORTS; p++) begin
                own_mac_reg[p] <= '0;
            end
            port_en_reg     <= '1;
            overridden_reg  <= '0;
            count_reg       <= '0;
            res_action      <= ACT_BAD_LEN;
            res_egress_mask <= '0;
            res_table_full  <= 1'b0;
        end else begin
            if (cfg_we && cfg_idx <= REG_OWN_MAC3) begin
                own_mac_reg[cfg_idx[1:0]]    <= cfg_data;
                overridden_reg[cfg_idx[1:0]] <= 1'b0;
            end else if (cfg_we && cfg_idx == REG_PORT_EN) begin
                port_en_reg <= cfg_data[MAX_PORTS-1:0];
            end
            if (cmd.learn) begin
                res_table_full <= !hit_reg && count_reg >= CNT_W'(TABLE_DEPTH);
                if (hit_reg || count_reg < CNT_W'(TABLE_DEPTH)) begin
                    if (!hit_reg) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    for (int p = 0; p < NUM_PORTS; p++) begin
                        if (port_en_reg[p] && own_mac_reg[p] == src_reg) begin
                            overridden_reg[p] <= 1'b1;
                        end
                    end
                end
            end
            if (cmd.finish) begin
                if (len_bad_reg) begin
                    res_action      <= ACT_BAD_LEN;
                    res_egress_mask <= '0;
                    res_table_full  <= 1'b0;
                end else begin
                    res_action <= own_hit ? ACT_OWN_MAC
                                : (hit_reg ? ACT_FORWARD : ACT_FLOOD);
                    res_egress_mask <= own_hit ? '0
                        : hit_reg
                        ? (MAX_PORTS'(1) << hit_port_reg) & PORTS_MASK
                        : port_en_reg & PORTS_MASK & ~(MAX_PORTS'(1) << ing_reg);
                end
            end
        end
    end

endmodule

>>> hw/rtl/mlsf_ctrl.sv
// ----------------------------------------------------------------------------
// mlsf_ctrl
// Sequencer: capture, source scan, learn, destination scan, result.
// ----------------------------------------------------------------------------
module mlsf_ctrl
    import mlsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  mlsf_sts_t sts,
    output mlsf_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_SRC, ST_LEARN, ST_DST, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;

    // accept a header once the previous result is gone or leaving
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = take;
                if (take) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = sts.len_bad ? ST_DONE : ST_SRC;
            end
            ST_SRC: begin
                cmd.scan_src = 1'b1;
                if (sts.scan_last) state_next = ST_LEARN;
            end
            ST_LEARN: begin
                cmd.learn  = 1'b1;
                state_next = ST_DST;
            end
            ST_DST: begin
                cmd.scan_dst = 1'b1;
                if (sts.scan_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/mac_learning_switch_forwarder.sv
// ----------------------------------------------------------------------------
// mac_learning_switch_forwarder
// Learning bridge forwarding decision for one frame header per transfer.
// ----------------------------------------------------------------------------
// One header is handled at a time. The table memory is swept once for the
// source and once for the destination, over the learned entries only; a
// bad-length frame skips both sweeps. A new header is taken once the previous
// result has left or leaves in the same cycle. No clearing pass after reset.
module mac_learning_switch_forwarder
    import mlsf_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int NUM_PORTS     = DEF_NUM_PORTS,
    parameter int MIN_FRAME_LEN = DEF_MIN_FRAME_LEN,
    parameter int MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [MAC_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dest_mac[47:0], source_mac[95:48], ingress_port[97:96], frame_len[111:98]
    input  logic [111:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // action[1:0], egress_mask[5:2], table_full[6]
    output logic [7:0]           m_tdata
);

    mlsf_cmd_t            cmd;
    mlsf_sts_t            sts;
    logic [1:0]           act;
    logic [MAX_PORTS-1:0] egr;
    logic                 full;

    mlsf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    mlsf_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH), .NUM_PORTS(NUM_PORTS),
        .MIN_FRAME_LEN(MIN_FRAME_LEN), .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_dest_mac(s_tdata[47:0]), .in_source_mac(s_tdata[95:48]),
        .in_ingress_port(s_tdata[97:96]), .in_frame_len(s_tdata[111:98]),
        .cmd(cmd), .sts(sts),
        .res_action(act), .res_egress_mask(egr), .res_table_full(full)
    );

    assign m_tdata = {1'b0, full, egr, act};

endmodule

>>> hw/rtl/mlsf_checker.sv
// ----------------------------------------------------------------------------
// mlsf_assertions
// Port-level checks of the forwarder, bound to the top level.
// ----------------------------------------------------------------------------
module mlsf_assertions (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // dropped frames go nowhere
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] == 1'b0 |-> m_tdata[5:2] == 4'd0)
        else $error("dropped frame has egress bits");

    // bad length never reports a full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> !m_tdata[6])
        else $error("bad length with table full");

    // no header taken in the cycle after one was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back to back header accepted");

endmodule

bind mac_learning_switch_forwarder mlsf_assertions u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
);

>>> test/mlsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsf_checker
// Watches the header and decision channels and the register port. It keeps
// its own copy of the address table and registers, works out the forwarding
// decision for each accepted header and compares it with the decision that
// comes back.
// ----------------------------------------------------------------------------
module mlsf_checker
    import mlsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [MAC_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [111:0]         s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,
    output int                   fail_count,
    output int                   pending
);

    localparam int DEPTH = DEF_TABLE_DEPTH;

    // packed from the top bit down: full[6], egress[5:2], action[1:0]
    typedef struct packed {
        logic       full;
        logic [3:0] egress;
        logic [1:0] action;
    } decision_t;

    // shadow registers and address table
    logic [MAC_W-1:0]  own_mac [MAX_PORTS];
    logic [3:0]        port_en;
    logic              own_taken [MAX_PORTS];
    logic [MAC_W-1:0]  tbl_mac [DEPTH];
    logic [PORT_W-1:0] tbl_port [DEPTH];
    int                tbl_used;

    decision_t decisions_due [$];

    function automatic int lookup(logic [MAC_W-1:0] mac);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_mac[i] == mac) return i;
        return -1;
    endfunction

    // forwarding decision for one header, updating the shadow table
    function automatic decision_t decide(logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
                                         logic [PORT_W-1:0] ingress,
                                         logic [LEN_W-1:0] len);
        decision_t d;
        int        idx;
        logic      learned;
        d = '0;
        learned = 1'b0;
        if (len + CRC_BYTES < DEF_MIN_FRAME_LEN || len + CRC_BYTES > DEF_MAX_FRAME_LEN) begin
            d.action = ACT_BAD_LEN;
            return d;
        end
        idx = lookup(src);
        if (idx >= 0) begin
            tbl_port[idx] = ingress;
            learned = 1'b1;
        end else if (tbl_used < DEPTH) begin
            tbl_mac[tbl_used] = src;
            tbl_port[tbl_used] = ingress;
            tbl_used++;
            learned = 1'b1;
        end else begin
            d.full = 1'b1;
        end
        if (learned)
            for (int p = 0; p < MAX_PORTS; p++)
                if (port_en[p] && own_mac[p] == src) own_taken[p] = 1'b1;
        d.action = ACT_FLOOD;
        for (int p = 0; p < MAX_PORTS; p++)
            if (port_en[p] && !own_taken[p] && own_mac[p] == dst) d.action = ACT_OWN_MAC;
        if (d.action != ACT_OWN_MAC) begin
            idx = lookup(dst);
            if (idx >= 0) begin
                d.action = ACT_FORWARD;
                d.egress = 4'b0001 << tbl_port[idx];
            end else begin
                d.egress = port_en & ~(4'b0001 << ingress);
            end
        end
        return d;
    endfunction

    assign pending = decisions_due.size();

    always @(posedge aclk) begin
        decision_t want, got;
        if (!aresetn) begin
            for (int p = 0; p < MAX_PORTS; p++) begin
                own_mac[p] = '0;
                own_taken[p] = 1'b0;
            end
            port_en = 4'hF;
            tbl_used = 0;
            fail_count = 0;
            decisions_due.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                if (cfg_idx <= REG_OWN_MAC3) begin
                    own_mac[cfg_idx[1:0]] = cfg_data;
                    own_taken[cfg_idx[1:0]] = 1'b0;
                end else if (cfg_idx == REG_PORT_EN) begin
                    port_en = cfg_data[3:0];
                end
            end
            // header transfer
            if (s_tvalid && s_tready)
                decisions_due.push_back(decide(s_tdata[47:0], s_tdata[95:48],
                                               s_tdata[97:96], s_tdata[111:98]));
            // decision transfer
            if (m_tvalid && m_tready) begin
                got = m_tdata[6:0];
                if (decisions_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected decision transfer %h", m_tdata);
                end else begin
                    want = decisions_due.pop_front();
                    if (got != want || m_tdata[7] !== 1'b0) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("decision mismatch: action %0d/%0d egress %b/%b full %b/%b",
                                     want.action, got.action, want.egress, got.egress,
                                     want.full, got.full);
                    end
                end
            end
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives frame headers and register writes into the learning switch
// forwarder through several register settings, with random idling on both
// sides and one long output stall; the checker judges every decision.
// ----------------------------------------------------------------------------
module testbench;
    import mlsf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC1 = REG_OWN_MAC0 + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC2 = REG_OWN_MAC0 + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;
    localparam logic [MAC_W-1:0]     MAC_ONES     = '1;
    localparam int                   POOL_SIZE    = 76;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [MAC_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [111:0]         s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    int                   fail_count;
    int                   pending;

    logic [MAC_W-1:0] host_pool [POOL_SIZE];
    logic [MAC_W-1:0] own_set [MAX_PORTS];
    int               headers_sent = 0;
    logic             calm = 1'b0;

    always #5 aclk = ~aclk;

    mac_learning_switch_forwarder dut (.*);

    mlsf_checker u_checker (.*);

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAC_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        if (idx <= REG_OWN_MAC3) own_set[idx[1:0]] = value;
    endtask

    // one header transfer, followed now and then by an idle burst
    task automatic send_header(logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
                               logic [PORT_W-1:0] port, logic [LEN_W-1:0] len);
        s_tvalid <= 1'b1;
        s_tdata  <= {len, port, src, dst};
        do @(posedge aclk); while (!s_tready);
        headers_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send_random();
        logic [MAC_W-1:0] dst, src;
        logic [LEN_W-1:0] len;
        int               pick;
        pick = $urandom_range(0, 19);
        if (pick < 16)      src = host_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 19) src = own_set[$urandom_range(0, MAX_PORTS - 1)];
        else                src = rand_mac();
        pick = $urandom_range(0, 19);
        if (pick < 12)      dst = host_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 16) dst = own_set[$urandom_range(0, MAX_PORTS - 1)];
        else if (pick < 18) dst = rand_mac();
        else                dst = MAC_ONES;
        pick = $urandom_range(0, 19);
        if (pick < 16)      len = LEN_W'($urandom_range(60, 1514));
        else if (pick < 18) len = LEN_W'($urandom_range(0, 59));
        else                len = LEN_W'($urandom_range(1515, 16383));
        send_header(dst, src, PORT_W'($urandom_range(0, 3)), len);
    endtask

    // let every decision drain before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // receiver: random stalls plus one long hold-off
    initial begin
        logic held_long;
        held_long = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!held_long && headers_sent >= 300) begin
                held_long = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) host_pool[i] = rand_mac();
        for (int p = 0; p < MAX_PORTS; p++) own_set[p] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: length limits, own address at reset, learning own address
        send_header(48'h0, host_pool[0], 2'd0, 14'd0);
        send_header(48'h0, host_pool[0], 2'd1, 14'd59);
        send_header(48'h0, host_pool[0], 2'd2, 14'd1515);
        send_header(MAC_ONES, MAC_ONES, 2'd3, 14'h3FFF);
        send_header(48'h0, host_pool[0], 2'd0, 14'd60);
        send_header(host_pool[0], host_pool[1], 2'd1, 14'd1514);
        send_header(host_pool[1], host_pool[0], 2'd3, 14'd100);
        send_header(host_pool[0], host_pool[0], 2'd0, 14'd64);
        send_header(48'h0, 48'h0, 2'd2, 14'd200);
        send_header(48'h0, host_pool[1], 2'd3, 14'd200);
        send_header(MAC_ONES, MAC_ONES, 2'd3, 14'd1514);
        send_header(MAC_ONES, host_pool[2], 2'd0, 14'd60);
        send_header(host_pool[3], host_pool[2], 2'd2, 14'd500);
        drain();

        // own addresses from the host pool, full port set
        write_reg(REG_OWN_MAC0, host_pool[70]);
        write_reg(REG_OWN_MAC1, host_pool[71]);
        write_reg(REG_OWN_MAC2, host_pool[72]);
        write_reg(REG_OWN_MAC3, host_pool[73]);
        write_reg(REG_PORT_EN, 48'hF);
        write_reg(REG_SPARE, MAC_ONES);
        repeat (300) send_random();
        drain();

        // no port enabled, extreme own addresses; rewrite clears overrides
        write_reg(REG_OWN_MAC0, host_pool[70]);
        write_reg(REG_OWN_MAC3, MAC_ONES);
        write_reg(REG_OWN_MAC1, 48'h0);
        write_reg(REG_PORT_EN, 48'h0);
        repeat (230) send_random();
        drain();

        // partial port sets
        write_reg(REG_OWN_MAC2, host_pool[$urandom_range(0, POOL_SIZE - 1)]);
        write_reg(REG_OWN_MAC1, host_pool[71]);
        write_reg(REG_PORT_EN, 48'h5);
        repeat (120) send_random();
        drain();
        write_reg(REG_PORT_EN, {44'h0, 4'($urandom)});
        repeat (120) send_random();
        drain();

        // all ports back, last part without idling
        write_reg(REG_OWN_MAC0, host_pool[$urandom_range(0, POOL_SIZE - 1)]);
        write_reg(REG_PORT_EN, 48'hF);
        repeat (150) send_random();
        calm = 1'b1;
        repeat (100) send_random();
        s_tvalid <= 1'b0;

        do @(negedge aclk); while (pending != 0);
        repeat (150) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
